### hdl/tqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue package
// Shared types, operation and status codes, and sizes for the timer queue.
// ----------------------------------------------------------------------------
package tqt_pkg;

	localparam int DEF_SLOTS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam logic [31:0] BAD_MASK_BITS = 32'h8000_00ff;

	localparam logic [3:0] OP_VBLANK    = 4'd0;
	localparam logic [3:0] OP_TICK      = 4'd1;
	localparam logic [3:0] OP_DELAY_VBL = 4'd2;
	localparam logic [3:0] OP_UNTIL_VBL = 4'd3;
	localparam logic [3:0] OP_METRO_VBL = 4'd4;
	localparam logic [3:0] OP_DELAY_TK  = 4'd5;
	localparam logic [3:0] OP_UNTIL_TK  = 4'd6;
	localparam logic [3:0] OP_METRO_TK  = 4'd7;
	localparam logic [3:0] OP_ABORT     = 4'd8;
	localparam logic [3:0] OP_GET_VBL   = 4'd9;
	localparam logic [3:0] OP_GET_TK    = 4'd10;
	localparam logic [3:0] OP_SET_VBL   = 4'd11;
	localparam logic [3:0] OP_SET_TK    = 4'd12;

	localparam logic [1:0] KIND_DONE   = 2'd0;
	localparam logic [1:0] KIND_SIGNAL = 2'd1;
	localparam logic [1:0] KIND_TIME   = 2'd2;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_ABORTED = 3'd1;
	localparam logic [2:0] STAT_BAD_ARG = 3'd2;
	localparam logic [2:0] STAT_NOT_SUP = 3'd3;
	localparam logic [2:0] STAT_CONFLICT = 3'd4;

	typedef struct packed {
		logic [3:0]  op;
		logic [3:0]  slot;
		logic [63:0] amount;
		logic [31:0] signal_mask;
	} req_t;

	typedef struct packed {
		logic [3:0]  out_slot;
		logic [1:0]  kind;
		logic [2:0]  status;
		logic [63:0] value;
		logic [31:0] out_mask;
		logic        last;
	} res_t;

	// One stored slot entry.
	typedef struct packed {
		logic        is_vbl;
		logic        periodic;
		logic [63:0] target;
		logic [31:0] count;
		logic [63:0] interval;
		logic [31:0] mask;
	} slot_t;

	typedef struct packed {
		logic push;
		logic flush;
		res_t data;
	} emit_ctl_t;

	typedef struct packed {
		logic blk;
		logic pend;
	} oq_stat_t;

endpackage

### hdl/tqt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module tqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/tqt_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result staging
// Holds one pending result until the next one or the end of the request
// shows whether it is the last, then moves it to the output register.
// ----------------------------------------------------------------------------
module tqt_outq
	import tqt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  emit_ctl_t ctl,
	output oq_stat_t  stat,
	output logic      res_valid,
	input  logic      res_stall,
	output res_t      res_data
);

	logic res_valid_q;
	logic pend_v_q;
	res_t pend_q;
	res_t res_q;
	logic out_free;
	logic load_next;
	logic load_last;

	assign out_free  = !res_valid_q || !res_stall;
	assign stat.blk  = pend_v_q && !out_free;
	assign stat.pend = pend_v_q;
	assign load_next = ctl.push && !stat.blk;
	assign load_last = !ctl.push && ctl.flush && pend_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (load_next) begin
				if (pend_v_q) begin
					res_valid_q <= 1'b1;
				end
				pend_v_q <= 1'b1;
			end else if (load_last) begin
				res_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end
		end
	end

	// The last flag is the lowest bit of the result word.
	always_ff @(posedge clk) begin
		if (load_next) begin
			if (pend_v_q) begin
				res_q <= {pend_q[$bits(res_t)-1:1], 1'b0};
			end
			pend_q <= ctl.data;
		end else if (load_last) begin
			res_q <= {pend_q[$bits(res_t)-1:1], 1'b1};
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

### hdl/vblank_and_tick_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vblank and tick timer queue
// Request slots for vblank countdowns and tick deadlines, one-shot or
// periodic, served by a sequencer that walks the slot memory.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds req_stall high until every
// result of that request has left the staging register. Commands (abort, get
// or set time, arming a vblank slot) finish without a walk of the slots. A
// vblank event reads and updates every slot in turn. A tick event, and arming
// a tick slot, runs a deadline check: each pass scans every slot through the
// single read port of the slot memory to find the earliest expired deadline,
// then fires it; passes repeat until none is left or the result limit is hit.
// Results leave in order; the last result of a request carries last set, and
// a request with no result gives no output at all.
// ----------------------------------------------------------------------------
module vblank_and_tick_timer_queue
	import tqt_pkg::*;
#(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [4:0] NMAX = 5'(MAX_RESULTS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VB_RD,
		ST_VB_EV,
		ST_TK_START,
		ST_TK_RD,
		ST_TK_EV,
		ST_TK_FRD,
		ST_TK_FIRE,
		ST_FLUSH
	} state_t;

	state_t           state_q;
	logic [63:0]      vclk_q;
	logic [63:0]      tclk_q;
	logic [SLOTS-1:0] busy_q;
	logic [SLOTS-1:0] done_q;
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    best_q;
	logic             best_v_q;
	logic [63:0]      best_tgt_q;
	logic [4:0]       n_q;

	logic        accept;
	logic        we;
	logic [IW-1:0] waddr;
	logic [IW-1:0] raddr;
	slot_t       wword;
	slot_t       rword;
	emit_ctl_t   ectl;
	oq_stat_t    ostat;
	res_t        e;

	logic [IW-1:0] req_idx;
	logic        slot_bad;
	logic        is_arm;
	logic        mask_bad;
	logic [31:0] cnt1;
	logic        vb_act;
	logic        vb_fire;
	logic        tk_cand;
	logic        tk_take;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign req_idx   = IW'(req_data.slot);
	assign slot_bad  = (32'(req_data.slot) >= SLOTS);
	assign is_arm    = (req_data.op >= OP_DELAY_VBL) && (req_data.op <= OP_METRO_TK);
	assign mask_bad  = ((req_data.op == OP_METRO_VBL) || (req_data.op == OP_METRO_TK))
		&& ((req_data.signal_mask & BAD_MASK_BITS) != 32'd0);

	assign raddr = ((state_q == ST_TK_FRD) || (state_q == ST_TK_FIRE)) ? best_q : idx_q;

	tqt_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wword),
		.raddr (raddr),
		.rdata (rword)
	);

	tqt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ectl),
		.stat      (ostat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// Vblank slot update and deadline compare share the same read word.
	assign cnt1    = rword.count + 32'd1;
	assign vb_act  = busy_q[idx_q] && rword.is_vbl;
	assign vb_fire = vb_act && (cnt1 >= rword.target[31:0]) && (n_q < NMAX);
	assign tk_cand = busy_q[idx_q] && !rword.is_vbl && !done_q[idx_q]
		&& (rword.target <= tclk_q);
	assign tk_take = tk_cand && (!best_v_q || (rword.target < best_tgt_q));

	// Result, memory write and staging control for the current state.
	always_comb begin
		e          = '0;
		ectl.push  = 1'b0;
		ectl.flush = 1'b0;
		we         = 1'b0;
		waddr      = idx_q;
		wword      = rword;
		e.out_slot = req_data.slot;
		e.kind     = KIND_DONE;
		e.status   = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				waddr          = req_idx;
				wword.is_vbl   = (req_data.op <= OP_METRO_VBL);
				wword.periodic = (req_data.op == OP_METRO_VBL)
					|| (req_data.op == OP_METRO_TK);
				wword.count    = '0;
				wword.mask     = req_data.signal_mask;
				wword.interval = '0;
				wword.target   = req_data.amount;
				case (req_data.op)
					OP_DELAY_VBL, OP_METRO_VBL: begin
						wword.target = {32'd0, req_data.amount[31:0]};
					end
					OP_UNTIL_VBL: begin
						wword.target = {32'd0, req_data.amount[31:0] - vclk_q[31:0]};
					end
					OP_DELAY_TK, OP_METRO_TK: begin
						wword.interval = req_data.amount;
						wword.target   = tclk_q + req_data.amount;
					end
					default: begin
					end
				endcase
				if (accept) begin
					case (req_data.op)
						OP_VBLANK, OP_TICK: begin
						end
						OP_GET_VBL: begin
							ectl.push = 1'b1;
							e.kind    = KIND_TIME;
							e.value   = vclk_q;
						end
						OP_GET_TK: begin
							ectl.push = 1'b1;
							e.kind    = KIND_TIME;
							e.value   = tclk_q;
						end
						OP_SET_TK: begin
							ectl.push = 1'b1;
						end
						OP_ABORT: begin
							ectl.push = 1'b1;
							if (slot_bad) begin
								e.status = STAT_BAD_ARG;
							end else if (busy_q[req_idx]) begin
								e.status = STAT_ABORTED;
							end else begin
								e.status = STAT_CONFLICT;
							end
						end
						default: begin
							if (is_arm) begin
								// A busy slot is reported before a bad mask.
								if (slot_bad) begin
									ectl.push = 1'b1;
									e.status  = STAT_BAD_ARG;
								end else if (busy_q[req_idx]) begin
									ectl.push = 1'b1;
									e.status  = STAT_CONFLICT;
								end else if (mask_bad) begin
									ectl.push = 1'b1;
									e.status  = STAT_BAD_ARG;
								end else begin
									we = 1'b1;
								end
							end else begin
								ectl.push = 1'b1;
								e.status  = STAT_NOT_SUP;
							end
						end
					endcase
				end
			end
			ST_VB_EV: begin
				e.out_slot = 4'(idx_q);
				if (vb_fire) begin
					ectl.push = 1'b1;
					if (rword.periodic) begin
						e.kind     = KIND_SIGNAL;
						e.out_mask = rword.mask;
					end
				end
				wword.count = (vb_fire && rword.periodic) ? 32'd0 : cnt1;
				we = vb_act && !(vb_fire && ostat.blk);
			end
			ST_TK_FIRE: begin
				e.out_slot   = 4'(best_q);
				ectl.push    = 1'b1;
				waddr        = best_q;
				wword.target = rword.target + rword.interval;
				if (rword.periodic) begin
					e.kind     = KIND_SIGNAL;
					e.out_mask = rword.mask;
					we         = !ostat.blk;
				end
			end
			ST_FLUSH: begin
				ectl.flush = 1'b1;
			end
			default: begin
			end
		endcase
		ectl.data = e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vclk_q     <= '0;
			tclk_q     <= '0;
			busy_q     <= '0;
			done_q     <= '0;
			idx_q      <= '0;
			best_q     <= '0;
			best_v_q   <= 1'b0;
			best_tgt_q <= '0;
			n_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q    <= '0;
						idx_q  <= '0;
						done_q <= '0;
						case (req_data.op)
							OP_VBLANK: begin
								vclk_q  <= vclk_q + 64'd1;
								state_q <= ST_VB_RD;
							end
							OP_TICK: begin
								tclk_q  <= tclk_q + 64'd1;
								state_q <= ST_TK_START;
							end
							OP_SET_TK: begin
								tclk_q  <= req_data.amount;
								state_q <= ST_FLUSH;
							end
							OP_ABORT: begin
								if (!slot_bad) begin
									busy_q[req_idx] <= 1'b0;
								end
								state_q <= ST_FLUSH;
							end
							default: begin
								state_q <= ST_FLUSH;
								if (is_arm && !slot_bad && !mask_bad && !busy_q[req_idx]) begin
									busy_q[req_idx] <= 1'b1;
									if (req_data.op > OP_METRO_VBL) begin
										state_q <= ST_TK_START;
									end
								end
							end
						endcase
					end
				end
				ST_VB_RD: begin
					state_q <= ST_VB_EV;
				end
				ST_VB_EV: begin
					if (!(vb_fire && ostat.blk)) begin
						if (vb_fire) begin
							n_q <= n_q + 5'd1;
							if (!rword.periodic) begin
								busy_q[idx_q] <= 1'b0;
							end
						end
						if (idx_q == LAST_IDX) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_VB_RD;
						end
					end
				end
				ST_TK_START: begin
					idx_q    <= '0;
					best_v_q <= 1'b0;
					state_q  <= (n_q >= NMAX) ? ST_FLUSH : ST_TK_RD;
				end
				ST_TK_RD: begin
					state_q <= ST_TK_EV;
				end
				ST_TK_EV: begin
					if (tk_take) begin
						best_v_q   <= 1'b1;
						best_q     <= idx_q;
						best_tgt_q <= rword.target;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= (best_v_q || tk_take) ? ST_TK_FRD : ST_FLUSH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_TK_RD;
					end
				end
				ST_TK_FRD: begin
					state_q <= ST_TK_FIRE;
				end
				ST_TK_FIRE: begin
					if (!ostat.blk) begin
						done_q[best_q] <= 1'b1;
						n_q <= n_q + 5'd1;
						if (!rword.periodic) begin
							busy_q[best_q] <= 1'b0;
						end
						state_q <= ST_TK_START;
					end
				end
				ST_FLUSH: begin
					if (!ostat.blk) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_result_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NMAX)
		else $error("more results than the per-request limit");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ostat.pend)
		else $error("pending result left behind at idle");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second request taken while one is in work");

	a_fire_has_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TK_FIRE) |-> best_v_q)
		else $error("deadline fire without an expired slot");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue testbench
// Drives random and directed timer commands and events into the timer queue,
// predicts every result with a software copy of the slot state, and checks
// the results in order under random idling and stalling on both channels.
// ----------------------------------------------------------------------------
import tqt_pkg::*;

// Holds the slot state, predicts results, and checks them in order.
class timer_scoreboard;
	logic [63:0] vbl_clock;
	logic [63:0] tk_clock;
	logic        busy [DEF_SLOTS];
	slot_t       slots [DEF_SLOTS];
	res_t        pending [$];
	int          errors;
	int          n_out;

	function new();
		vbl_clock = '0;
		tk_clock = '0;
		errors = 0;
		foreach (busy[i]) busy[i] = 1'b0;
	endfunction

	function void push_res(logic [3:0] s, logic [1:0] k, logic [2:0] st,
			logic [63:0] v, logic [31:0] m);
		res_t r;
		if (n_out >= MAX_RESULTS) return;
		r.out_slot = s;
		r.kind = k;
		r.status = st;
		r.value = v;
		r.out_mask = m;
		r.last = 1'b0;
		pending.push_back(r);
		n_out++;
	endfunction

	// Deadline check: earliest expired tick target first, ties by slot,
	// each slot at most once per check.
	function void deadline_check();
		logic done [DEF_SLOTS];
		int best;
		foreach (done[i]) done[i] = 1'b0;
		while (n_out < MAX_RESULTS) begin
			best = -1;
			for (int i = 0; i < DEF_SLOTS; i++) begin
				if (!busy[i] || slots[i].is_vbl || done[i]) continue;
				if (slots[i].target > tk_clock) continue;
				if (best < 0 || slots[i].target < slots[best].target) best = i;
			end
			if (best < 0) break;
			done[best] = 1'b1;
			if (slots[best].periodic) begin
				slots[best].target += slots[best].interval;
				push_res(best[3:0], KIND_SIGNAL, STAT_OK, '0, slots[best].mask);
			end else begin
				busy[best] = 1'b0;
				push_res(best[3:0], KIND_DONE, STAT_OK, '0, '0);
			end
		end
	endfunction

	function void vblank_event();
		vbl_clock++;
		for (int i = 0; i < DEF_SLOTS; i++) begin
			if (!busy[i] || !slots[i].is_vbl) continue;
			slots[i].count++;
			if (slots[i].count < slots[i].target[31:0] || n_out >= MAX_RESULTS)
				continue;
			if (slots[i].periodic) begin
				slots[i].count = '0;
				push_res(i[3:0], KIND_SIGNAL, STAT_OK, '0, slots[i].mask);
			end else begin
				busy[i] = 1'b0;
				push_res(i[3:0], KIND_DONE, STAT_OK, '0, '0);
			end
		end
	endfunction

	// Notes an accepted request and queues its expected results.
	function void note_request(req_t q);
		int first;
		first = pending.size();
		n_out = 0;
		case (q.op)
			OP_VBLANK: vblank_event();
			OP_TICK: begin
				tk_clock++;
				deadline_check();
			end
			OP_DELAY_VBL, OP_UNTIL_VBL, OP_METRO_VBL, OP_DELAY_TK, OP_UNTIL_TK,
			OP_METRO_TK, OP_ABORT: begin
				if (q.op == OP_ABORT) begin
					if (busy[q.slot]) begin
						busy[q.slot] = 1'b0;
						push_res(q.slot, KIND_DONE, STAT_ABORTED, '0, '0);
					end else push_res(q.slot, KIND_DONE, STAT_CONFLICT, '0, '0);
				end else if (busy[q.slot]) begin
					push_res(q.slot, KIND_DONE, STAT_CONFLICT, '0, '0);
				end else if ((q.op == OP_METRO_VBL || q.op == OP_METRO_TK) &&
						(q.signal_mask & BAD_MASK_BITS) != 0) begin
					push_res(q.slot, KIND_DONE, STAT_BAD_ARG, '0, '0);
				end else if (q.op <= OP_METRO_VBL) begin
					busy[q.slot] = 1'b1;
					slots[q.slot].is_vbl = 1'b1;
					slots[q.slot].periodic = (q.op == OP_METRO_VBL);
					slots[q.slot].count = '0;
					slots[q.slot].interval = '0;
					slots[q.slot].mask = q.signal_mask;
					if (q.op == OP_UNTIL_VBL)
						slots[q.slot].target = {32'd0, q.amount[31:0] - vbl_clock[31:0]};
					else
						slots[q.slot].target = {32'd0, q.amount[31:0]};
				end else begin
					busy[q.slot] = 1'b1;
					slots[q.slot].is_vbl = 1'b0;
					slots[q.slot].periodic = (q.op == OP_METRO_TK);
					slots[q.slot].count = '0;
					slots[q.slot].mask = q.signal_mask;
					if (q.op == OP_UNTIL_TK) begin
						slots[q.slot].interval = '0;
						slots[q.slot].target = q.amount;
					end else begin
						slots[q.slot].interval = q.amount;
						slots[q.slot].target = tk_clock + q.amount;
					end
					deadline_check();
				end
			end
			OP_GET_VBL: push_res(q.slot, KIND_TIME, STAT_OK, vbl_clock, '0);
			OP_GET_TK: push_res(q.slot, KIND_TIME, STAT_OK, tk_clock, '0);
			OP_SET_VBL: push_res(q.slot, KIND_DONE, STAT_NOT_SUP, '0, '0);
			OP_SET_TK: begin
				tk_clock = q.amount;
				push_res(q.slot, KIND_DONE, STAT_OK, '0, '0);
			end
			default: push_res(q.slot, KIND_DONE, STAT_NOT_SUP, '0, '0);
		endcase
		if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
	endfunction

	// Compares one accepted result with the oldest expected one.
	function void check_result(res_t got);
		res_t want;
		if (pending.size() == 0) begin
			$error("unexpected result %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.out_slot !== want.out_slot) begin
			$error("out_slot: expected %0d actual %0d", want.out_slot, got.out_slot);
			errors++;
		end
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d actual %0d", want.kind, got.kind);
			errors++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d actual %0d", want.status, got.status);
			errors++;
		end
		if (got.value !== want.value) begin
			$error("value: expected %h actual %h", want.value, got.value);
			errors++;
		end
		if (got.out_mask !== want.out_mask) begin
			$error("out_mask: expected %h actual %h", want.out_mask, got.out_mask);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d actual %0d", want.last, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	// Idle percentages for the sender and the receiver, set per phase.
	int send_idle = 0;
	int recv_idle = 0;
	// Long receiver hold-off, counted down in cycles by the receiver process.
	int hold_cycles = 0;

	timer_scoreboard board;

	vblank_and_tick_timer_queue u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always #2 clk = ~clk;

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

	// The receiver checks every accepted result and picks its next stall value
	// at the same edge, so only one nonblocking update happens per step.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) board.check_result(res_data);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// Offers one request, with random idle cycles before it, and returns once
	// the block has taken it. Valid stays high into the next request unless
	// the sender idles, so it is updated only once per edge.
	task automatic send_request(input req_t q);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_request(q);
	endtask

	task automatic send_cmd(input logic [3:0] op, input logic [3:0] s,
			input logic [63:0] amt, input logic [31:0] m);
		req_t q;
		q.op = op;
		q.slot = s;
		q.amount = amt;
		q.signal_mask = m;
		send_request(q);
	endtask

	// Waits until every expected result has arrived, plus a short settle.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// Random request, mostly well-formed arming with small times, plenty of
	// events, and a few full-range values and odd codes.
	task automatic send_random();
		req_t q;
		int pick;
		pick = $urandom_range(99);
		q.slot = 4'($urandom_range(15));
		q.amount = {$urandom, $urandom};
		q.signal_mask = $urandom;
		if ($urandom_range(1) != 0) q.signal_mask[7:0] = 8'h00;
		if ($urandom_range(3) != 0) q.signal_mask[31] = 1'b0;
		if ($urandom_range(3) != 0) q.amount = 64'($urandom_range(8));
		if (pick < 25) q.op = OP_TICK;
		else if (pick < 40) q.op = OP_VBLANK;
		else if (pick < 80) q.op = 4'($urandom_range(OP_DELAY_VBL, OP_METRO_TK));
		else if (pick < 88) q.op = OP_ABORT;
		else if (pick < 97) q.op = 4'($urandom_range(OP_GET_VBL, OP_SET_TK));
		else q.op = 4'($urandom_range(13, 15));
		// Big jumps of the tick clock are kept rare so deadlines stay reachable.
		if (q.op == OP_SET_TK && $urandom_range(4) != 0) q.amount = 64'($urandom_range(40));
		if (q.op == OP_UNTIL_TK && $urandom_range(7) != 0)
			q.amount = board.tk_clock + 64'($urandom_range(6));
		send_request(q);
	endtask

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: each operation, field extremes and special cases.
		send_cmd(OP_GET_VBL, 4'd0, '0, '0);
		send_cmd(OP_GET_TK, 4'd15, '1, '1);
		send_cmd(OP_SET_VBL, 4'd3, 64'd5, '0);
		send_cmd(4'd13, 4'd1, '0, '0);
		send_cmd(4'd15, 4'd15, '1, '1);
		send_cmd(OP_ABORT, 4'd2, '0, '0);
		send_cmd(OP_METRO_VBL, 4'd4, 64'd2, 32'h0000_0001);
		send_cmd(OP_METRO_TK, 4'd4, 64'd2, 32'h8000_0000);
		send_cmd(OP_METRO_VBL, 4'd4, 64'd2, 32'h7fff_ff00);
		send_cmd(OP_DELAY_VBL, 4'd4, 64'd1, '0);
		send_cmd(OP_UNTIL_VBL, 4'd5, 64'd3, '0);
		send_cmd(OP_DELAY_VBL, 4'd6, 64'hffff_ffff_0000_0000, '0);
		send_cmd(OP_VBLANK, 4'd0, '0, '0);
		send_cmd(OP_VBLANK, 4'd0, '0, '0);
		send_cmd(OP_ABORT, 4'd4, '0, '0);
		send_cmd(OP_DELAY_TK, 4'd7, 64'd0, '0);
		send_cmd(OP_METRO_TK, 4'd8, 64'd1, 32'h0000_ff00);
		send_cmd(OP_UNTIL_TK, 4'd9, 64'd3, '0);
		send_cmd(OP_TICK, 4'd0, '0, '0);
		send_cmd(OP_SET_TK, 4'd0, '1, '0);
		send_cmd(OP_UNTIL_TK, 4'd10, '1, '0);
		send_cmd(OP_TICK, 4'd0, '0, '0);
		send_cmd(OP_SET_TK, 4'd0, 64'd20, '0);
		send_cmd(OP_TICK, 4'd0, '0, '0);
		// Sender pause until everything has come back.
		drain_results();

		// Random part in idling phases; the first phase includes a long
		// receiver hold-off so the block backs up onto its input.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 71 : 18) : 0;
			recv_idle = (phase == 2) ? 71 : ((phase == 3) ? 18 : 0);
			if (phase == 0) hold_cycles = 600;
			for (int n = 0; n < 105; n++) send_random();
			if (phase == 1) drain_results();
		end

		drain_results();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
